// ----- rtl/core/cms_pkg.sv -----
// ----------------------------------------------------------------------------
// cms_pkg
// Shared types, constants and request/response structs of the count-min
// frequency sketch.
// ----------------------------------------------------------------------------
package cms_pkg;

	localparam int ROWS          = 4;
	localparam int ROW_BITS      = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int COL_BITS      = 14;
	localparam int ROW_WIDTH     = 1 << COL_BITS;
	localparam int CTR_BITS      = 4;
	localparam int MAX_KEY_BYTES = 8;
	localparam int NUM_SEEDS     = 4;
	localparam int SEED_BITS     = 2;
	localparam int EST_BITS      = 4;
	localparam int CFG_IDX_BITS  = 3;

	localparam logic [CTR_BITS-1:0] CTR_MAX = {CTR_BITS{1'b1}};

	localparam logic [31:0] MUR_C1 = 32'hcc9e2d51;
	localparam logic [31:0] MUR_C2 = 32'h1b873593;
	localparam logic [31:0] MUR_C3 = 32'he6546b64;
	localparam logic [31:0] MUR_C4 = 32'h85ebca6b;
	localparam logic [31:0] MUR_C5 = 32'hc2b2ae35;

	localparam logic [31:0] SEED_RESET   = 32'h12345678;
	localparam logic [31:0] DECAY_RESET  = 32'd15;

	localparam logic [1:0] OP_INC = 2'd0;
	localparam logic [1:0] OP_EST = 2'd1;
	localparam logic [1:0] OP_CLR = 2'd2;
	localparam logic [1:0] OP_NOP = 2'd3;

	localparam logic [CFG_IDX_BITS-1:0] CFG_SEED0 = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SEED1 = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SEED2 = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SEED3 = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DECAY = 3'd4;

	typedef logic [COL_BITS-1:0] col_t;
	typedef logic [CTR_BITS-1:0] ctr_t;

	typedef struct packed {
		logic        start;
		logic [31:0] seed;
		logic [63:0] key;
		logic [3:0]  len;
	} hash_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] hash;
	} hash_rsp_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] rem;
	} mod_rsp_t;

endpackage

// ----- rtl/core/cms_if.sv -----
// ----------------------------------------------------------------------------
// cms_item_if / cms_result_if
// Valid/ready channels carrying sketch requests and their results.
// ----------------------------------------------------------------------------
interface cms_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [63:0] key;
	logic [3:0]  key_bytes;

	modport source (output valid, output opcode, output key, output key_bytes, input ready);
	modport sink (input valid, input opcode, input key, input key_bytes, output ready);
endinterface

interface cms_result_if;
	logic        valid;
	logic        ready;
	logic [3:0]  estimate;
	logic        decay_done;
	logic [31:0] access_total;

	modport source (output valid, output estimate, output decay_done, output access_total,
		input ready);
	modport sink (input valid, input estimate, input decay_done, input access_total,
		output ready);
endinterface

// ----- rtl/core/count_min_frequency_sketch.sv -----
// ----------------------------------------------------------------------------
// count_min_frequency_sketch
// Count-min sketch with aging: per-row hashed saturating counters, increment,
// estimate, clear and periodic halving of all counters.
// ----------------------------------------------------------------------------
// channel   dir   handshake       payload
// item      in    valid/ready     opcode, key, key_bytes
// result    out   valid/ready     estimate, decay_done, access_total
// cfg       in    cfg_wr_en       cfg_index, cfg_wdata
//
// each row is hashed in turn on the one hash unit and its shared multiplier
// an increment also runs the bit-serial remainder of the access count when decay is nonzero
// a halving or clear sweeps all rows in parallel over every column
// after reset a clearing pass runs before the first request
// one request at a time; a new request is taken while the last result waits
// ----------------------------------------------------------------------------
module count_min_frequency_sketch
	import cms_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	cms_item_if.sink                item,
	cms_result_if.source            result,
	input  logic                    cfg_wr_en,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [31:0]             cfg_wdata
);

	typedef enum logic [2:0] {
		S_IDLE, S_HASH, S_READ, S_UPDATE, S_MOD, S_SWEEP, S_FINISH
	} state_t;

	state_t              state_q;
	logic [31:0]         seed_q [NUM_SEEDS];
	logic [31:0]         decay_q;
	logic [31:0]         access_q;
	logic [1:0]          op_q;
	logic [63:0]         key_q;
	logic [3:0]          len_q;
	logic [ROW_BITS-1:0] row_q;
	col_t                col_q [ROWS];
	logic [COL_BITS:0]   cnt_q;
	logic                halve_q, respond_q, hash_start_q, mod_start_q;
	logic [EST_BITS-1:0] est_q, res_est_q;
	logic                done_q, res_done_q, res_valid_q;
	logic [31:0]         res_total_q;

	logic                ram_we    [ROWS];
	col_t                ram_waddr [ROWS];
	ctr_t                ram_wdata [ROWS];
	col_t                ram_raddr [ROWS];
	ctr_t                ram_rdata [ROWS];

	hash_req_t           hash_req;
	hash_rsp_t           hash_rsp;
	mod_req_t            mod_req;
	mod_rsp_t            mod_rsp;

	logic                accept, sweeping, res_load;
	logic [3:0]          len_sat;
	col_t                cnt_m1;
	ctr_t                row_min;

	assign accept   = item.valid && item.ready;
	assign sweeping = (state_q == S_SWEEP);
	assign res_load = (state_q == S_FINISH) && (!res_valid_q || result.ready);
	assign len_sat  = (item.key_bytes > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES) : item.key_bytes;
	assign cnt_m1   = col_t'(cnt_q - 1'b1);

	assign hash_req.start = hash_start_q;
	assign hash_req.seed  = seed_q[SEED_BITS'(row_q)];
	assign hash_req.key   = key_q;
	assign hash_req.len   = len_q;

	assign mod_req.start    = mod_start_q;
	assign mod_req.dividend = access_q;
	assign mod_req.divisor  = decay_q;

	cms_hash u_hash (.clk(clk), .arst_n(arst_n), .req(hash_req), .rsp(hash_rsp));
	cms_mod u_mod (.clk(clk), .arst_n(arst_n), .req(mod_req), .rsp(mod_rsp));

	always_comb begin
		row_min = CTR_MAX;
		for (int r = 0; r < ROWS; r++) begin
			if (ram_rdata[r] < row_min) begin
				row_min = ram_rdata[r];
			end
			ram_raddr[r] = sweeping ? cnt_q[COL_BITS-1:0] : col_q[r];
			ram_waddr[r] = sweeping ? cnt_m1 : col_q[r];
			ram_wdata[r] = sweeping ? (halve_q ? (ram_rdata[r] >> 1) : '0)
				: (ram_rdata[r] + 1'b1);
			ram_we[r]    = (sweeping && (cnt_q != '0))
				|| ((state_q == S_UPDATE) && (op_q == OP_INC) && (ram_rdata[r] < CTR_MAX));
		end
	end

	for (genvar g = 0; g < ROWS; g++) begin : g_row
		cms_ram #(.WIDTH(CTR_BITS), .DEPTH(ROW_WIDTH)) u_ram (
			.clk   (clk),
			.we    (ram_we[g]),
			.waddr (ram_waddr[g]),
			.wdata (ram_wdata[g]),
			.raddr (ram_raddr[g]),
			.rdata (ram_rdata[g])
		);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SEEDS; i++) begin
				seed_q[i] <= SEED_RESET + 32'(i);
			end
			decay_q <= DECAY_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_SEED0: seed_q[0] <= cfg_wdata;
				CFG_SEED1: seed_q[1] <= cfg_wdata;
				CFG_SEED2: seed_q[2] <= cfg_wdata;
				CFG_SEED3: seed_q[3] <= cfg_wdata;
				CFG_DECAY: decay_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			cnt_q        <= '0;
			halve_q      <= 1'b0;
			respond_q    <= 1'b0;
			hash_start_q <= 1'b0;
			mod_start_q  <= 1'b0;
			access_q     <= 32'd0;
			row_q        <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			hash_start_q <= 1'b0;
			mod_start_q  <= 1'b0;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q   <= item.opcode;
						key_q  <= item.key;
						len_q  <= len_sat;
						row_q  <= '0;
						est_q  <= '0;
						done_q <= 1'b0;
						if (item.opcode == OP_INC || item.opcode == OP_EST) begin
							hash_start_q <= 1'b1;
							state_q      <= S_HASH;
						end else if (item.opcode == OP_CLR) begin
							access_q  <= 32'd0;
							cnt_q     <= '0;
							halve_q   <= 1'b0;
							respond_q <= 1'b1;
							state_q   <= S_SWEEP;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_HASH: begin
					if (hash_rsp.done) begin
						col_q[row_q] <= hash_rsp.hash[COL_BITS-1:0];
						if (row_q == ROW_BITS'(ROWS - 1)) begin
							state_q <= S_READ;
						end else begin
							row_q        <= row_q + 1'b1;
							hash_start_q <= 1'b1;
						end
					end
				end
				S_READ: state_q <= S_UPDATE;
				S_UPDATE: begin
					if (op_q == OP_INC) begin
						access_q <= access_q + 32'd1;
						if (decay_q != 32'd0) begin
							mod_start_q <= 1'b1;
							state_q     <= S_MOD;
						end else begin
							state_q <= S_FINISH;
						end
					end else begin
						est_q   <= EST_BITS'(row_min);
						state_q <= S_FINISH;
					end
				end
				S_MOD: begin
					if (mod_rsp.done) begin
						if (mod_rsp.rem == 32'd0) begin
							done_q    <= 1'b1;
							cnt_q     <= '0;
							halve_q   <= 1'b1;
							respond_q <= 1'b1;
							state_q   <= S_SWEEP;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_SWEEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (COL_BITS + 1)'(ROW_WIDTH)) begin
						state_q <= respond_q ? S_FINISH : S_IDLE;
					end
				end
				S_FINISH: begin
					if (res_load) begin
						res_est_q   <= est_q;
						res_done_q  <= done_q;
						res_total_q <= access_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign item.ready          = (state_q == S_IDLE);
	assign result.valid        = res_valid_q;
	assign result.estimate     = res_est_q;
	assign result.decay_done   = res_done_q;
	assign result.access_total = res_total_q;

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !item.ready)
		else $error("request taken while busy");
	a_mod_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		mod_req.start |-> (mod_req.divisor != 32'd0))
		else $error("remainder started with zero divisor");
	a_hash_state: assert property (@(posedge clk) disable iff (!arst_n)
		hash_req.start |-> (state_q == S_HASH))
		else $error("hash started outside hashing");
	a_decay_no_est: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_done_q) |-> (res_est_q == '0))
		else $error("halving result carries an estimate");

endmodule

// ----- rtl/core/cms_ram.sv -----
// ----------------------------------------------------------------------------
// cms_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cms_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/cms_hash.sv -----
// ----------------------------------------------------------------------------
// cms_hash
// Sequenced 32-bit murmur hash of a key up to 8 bytes, one shared multiplier.
// ----------------------------------------------------------------------------
module cms_hash
	import cms_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  hash_req_t req,
	output hash_rsp_t rsp
);

	typedef enum logic [3:0] {
		H_IDLE, H_BM1, H_BM2, H_BH, H_TM1, H_TM2, H_TH, H_FA, H_FB, H_FC
	} hstate_t;

	hstate_t     state_q;
	logic [31:0] h_q, k_q;
	logic [63:0] key_q;
	logic [3:0]  len_q;
	logic        blk_q;
	logic        done_q;

	logic [31:0] mul_a, mul_b, mul_p;
	logic [31:0] word, tail_word, tail_mask, fin_t, bh_t;
	logic [1:0]  nblk, blk_next;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
		return (x << r) | (x >> (32 - r));
	endfunction

	always_comb begin
		nblk      = len_q[3:2];
		blk_next  = {1'b0, blk_q} + 2'd1;
		word      = blk_q ? key_q[63:32] : key_q[31:0];
		case (len_q[1:0])
			2'd1:    tail_mask = 32'h000000ff;
			2'd2:    tail_mask = 32'h0000ffff;
			2'd3:    tail_mask = 32'h00ffffff;
			default: tail_mask = 32'h00000000;
		endcase
		tail_word = word & tail_mask;
		fin_t     = h_q ^ {28'd0, len_q};
		bh_t      = rotl(h_q ^ k_q, 13);
		mul_a     = 32'd0;
		mul_b     = 32'd0;
		case (state_q)
			H_BM1: begin
				mul_a = word;
				mul_b = MUR_C1;
			end
			H_TM1: begin
				mul_a = tail_word;
				mul_b = MUR_C1;
			end
			H_BM2, H_TM2: begin
				mul_a = rotl(k_q, 15);
				mul_b = MUR_C2;
			end
			H_FA: begin
				mul_a = fin_t ^ (fin_t >> 16);
				mul_b = MUR_C4;
			end
			H_FB: begin
				mul_a = h_q ^ (h_q >> 13);
				mul_b = MUR_C5;
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				H_IDLE: begin
					if (req.start) begin
						h_q   <= req.seed;
						key_q <= req.key;
						len_q <= req.len;
						blk_q <= 1'b0;
						if (req.len[3:2] != 2'd0) begin
							state_q <= H_BM1;
						end else if (req.len[1:0] != 2'd0) begin
							state_q <= H_TM1;
						end else begin
							state_q <= H_FA;
						end
					end
				end
				H_BM1: begin
					k_q     <= mul_p;
					state_q <= H_BM2;
				end
				H_BM2: begin
					k_q     <= mul_p;
					state_q <= H_BH;
				end
				H_BH: begin
					h_q   <= (bh_t << 2) + bh_t + MUR_C3;
					blk_q <= blk_next[0];
					if (blk_next != nblk) begin
						state_q <= H_BM1;
					end else if (len_q[1:0] != 2'd0) begin
						state_q <= H_TM1;
					end else begin
						state_q <= H_FA;
					end
				end
				H_TM1: begin
					k_q     <= mul_p;
					state_q <= H_TM2;
				end
				H_TM2: begin
					k_q     <= mul_p;
					state_q <= H_TH;
				end
				H_TH: begin
					h_q     <= h_q ^ k_q;
					state_q <= H_FA;
				end
				H_FA: begin
					h_q     <= mul_p;
					state_q <= H_FB;
				end
				H_FB: begin
					h_q     <= mul_p;
					state_q <= H_FC;
				end
				H_FC: begin
					h_q     <= h_q ^ (h_q >> 16);
					done_q  <= 1'b1;
					state_q <= H_IDLE;
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.hash = h_q;

endmodule

// ----- rtl/core/cms_mod.sv -----
// ----------------------------------------------------------------------------
// cms_mod
// Bit-serial restoring remainder of a 32-bit dividend by a 32-bit divisor.
// ----------------------------------------------------------------------------
module cms_mod
	import cms_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mod_req_t req,
	output mod_rsp_t rsp
);

	logic        busy_q, done_q;
	logic [4:0]  cnt_q;
	logic [31:0] dvd_q, dvs_q, rem_q;
	logic [32:0] trial, diff;

	always_comb begin
		trial = {rem_q, dvd_q[31]};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
				dvd_q  <= req.dividend;
				dvs_q  <= req.divisor;
				rem_q  <= 32'd0;
			end else if (busy_q) begin
				dvd_q <= {dvd_q[30:0], 1'b0};
				rem_q <= diff[32] ? trial[31:0] : diff[31:0];
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule
